/* hdl/icp_pkg.sv */
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types, register map and constants of the two-wire programming master.
// ----------------------------------------------------------------------------
package icp_pkg;

	// Default number of bits in a command frame or an entry or exit pattern.
	localparam int FRAME_BITS_DEF = 24;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Register word indexes (byte address divided by four).
	localparam logic [2:0] REG_SHORT_DELAY = 3'd0;
	localparam logic [2:0] REG_ENTRY_DELAY = 3'd1;
	localparam logic [2:0] REG_RESET_DELAY = 3'd2;
	localparam logic [2:0] REG_ENTRY_PAT   = 3'd3;
	localparam logic [2:0] REG_ALT_ENTRY   = 3'd4;
	localparam logic [2:0] REG_EXIT_PAT    = 3'd5;
	localparam logic [2:0] REG_RESET_PAT   = 3'd6;
	localparam logic [2:0] REG_ALT_RESET   = 3'd7;

	// Register reset values.
	localparam logic [7:0]  RST_SHORT_DELAY = 8'd2;
	localparam logic [9:0]  RST_ENTRY_DELAY = 10'd60;
	localparam logic [15:0] RST_RESET_DELAY = 16'd10000;
	localparam logic [23:0] RST_ENTRY_PAT   = 24'h5AA503;
	localparam logic [23:0] RST_ALT_ENTRY   = 24'h75BA03;
	localparam logic [23:0] RST_EXIT_PAT    = 24'h0F78F0;
	localparam logic [24:0] RST_RESET_PAT   = 25'h09E1CB6;
	localparam logic [24:0] RST_ALT_RESET   = 25'h0AE1CB6;

	// Request kinds.
	localparam logic [2:0] KIND_TICK      = 3'd0;
	localparam logic [2:0] KIND_COMMAND   = 3'd1;
	localparam logic [2:0] KIND_READ      = 3'd2;
	localparam logic [2:0] KIND_ENTRY     = 3'd3;
	localparam logic [2:0] KIND_EXIT      = 3'd4;
	localparam logic [2:0] KIND_RESET_PAT = 3'd5;
	localparam logic [2:0] KIND_SET_RESET = 3'd6;
	localparam logic [2:0] KIND_RESERVED  = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_TX_LOW,
		PH_TX_HIGH,
		PH_RS_HOLD,
		PH_RD_SETTLE,
		PH_RD_PRE,
		PH_RD_HIGH,
		PH_RD_END_DIR,
		PH_RD_END_SET,
		PH_RD_END_HIGH,
		PH_RD_END_LOW
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [5:0]  command_code;
		logic [17:0] operand;
		logic        end_flag;
		logic        alternate;
		logic        dat_in;
		logic        reset_level;
	} req_t;

	typedef struct packed {
		logic       clk_level;
		logic       dat_level;
		logic       dat_drive;
		logic       rst_level;
		logic       busy_res;
		logic [7:0] read_value;
		logic       read_valid;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  short_bit_delay;
		logic [9:0]  pattern_bit_delay;
		logic [15:0] reset_bit_delay;
		logic [23:0] entry_pattern;
		logic [23:0] alt_entry_pattern;
		logic [23:0] exit_pattern;
		logic [24:0] reset_pattern;
		logic [24:0] alt_reset_pattern;
	} cfg_t;

	// A delay of zero still holds for one tick.
	function automatic logic [15:0] hold_of(input logic [15:0] d);
		return (d == 16'd0) ? 16'd1 : d;
	endfunction

endpackage

/* hdl/icp_serial_programming_master.sv */
// ----------------------------------------------------------------------------
// icp_serial_programming_master
// Tick-driven master for a two-wire in-circuit programming link.
// ----------------------------------------------------------------------------
// Every transfer on the req channel is either one timing tick or a request,
// and it yields exactly one transfer on the rsp channel that shows the pin
// levels, busy flag and read byte after that item. The block takes one item
// per clock cycle while rsp does not stall: an item is registered on
// acceptance, stepped through the sequencer when it can advance, and its
// result is registered in rsp_q, which drives rsp. The rate is set by the
// sequencer step, which must finish before the next item can use the state it
// leaves; stalls on rsp hold the input register and push back on req only
// when both registers are full.
// ----------------------------------------------------------------------------
module icp_serial_programming_master #(
	parameter int FRAME_BITS = icp_pkg::FRAME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  icp_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output icp_pkg::rsp_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [icp_pkg::APB_AW-1:0]    paddr,
	input  logic [icp_pkg::APB_DW-1:0]    pwdata,
	output logic [icp_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import icp_pkg::*;

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	rsp_t rsp_next;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic advance;

	assign pready    = 1'b1;
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	icp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	icp_seq #(
		.FRAME_BITS (FRAME_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

/* hdl/icp_regs.sv */
// ----------------------------------------------------------------------------
// icp_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module icp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [icp_pkg::APB_AW-1:0]    paddr,
	input  logic [icp_pkg::APB_DW-1:0]    pwdata,
	output logic [icp_pkg::APB_DW-1:0]    prdata,
	output icp_pkg::cfg_t                 cfg
);
	import icp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] word_idx;
	logic       wr_en;

	assign word_idx = paddr[APB_AW-1:2];
	assign wr_en    = psel && penable && pwrite;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_bit_delay   <= RST_SHORT_DELAY;
			cfg_q.pattern_bit_delay <= RST_ENTRY_DELAY;
			cfg_q.reset_bit_delay   <= RST_RESET_DELAY;
			cfg_q.entry_pattern     <= RST_ENTRY_PAT;
			cfg_q.alt_entry_pattern <= RST_ALT_ENTRY;
			cfg_q.exit_pattern      <= RST_EXIT_PAT;
			cfg_q.reset_pattern     <= RST_RESET_PAT;
			cfg_q.alt_reset_pattern <= RST_ALT_RESET;
		end else if (wr_en) begin
			case (word_idx)
				REG_SHORT_DELAY: cfg_q.short_bit_delay   <= pwdata[7:0];
				REG_ENTRY_DELAY: cfg_q.pattern_bit_delay <= pwdata[9:0];
				REG_RESET_DELAY: cfg_q.reset_bit_delay   <= pwdata[15:0];
				REG_ENTRY_PAT:   cfg_q.entry_pattern     <= pwdata[23:0];
				REG_ALT_ENTRY:   cfg_q.alt_entry_pattern <= pwdata[23:0];
				REG_EXIT_PAT:    cfg_q.exit_pattern      <= pwdata[23:0];
				REG_RESET_PAT:   cfg_q.reset_pattern     <= pwdata[24:0];
				REG_ALT_RESET:   cfg_q.alt_reset_pattern <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (word_idx)
			REG_SHORT_DELAY: prdata = APB_DW'(cfg_q.short_bit_delay);
			REG_ENTRY_DELAY: prdata = APB_DW'(cfg_q.pattern_bit_delay);
			REG_RESET_DELAY: prdata = APB_DW'(cfg_q.reset_bit_delay);
			REG_ENTRY_PAT:   prdata = APB_DW'(cfg_q.entry_pattern);
			REG_ALT_ENTRY:   prdata = APB_DW'(cfg_q.alt_entry_pattern);
			REG_EXIT_PAT:    prdata = APB_DW'(cfg_q.exit_pattern);
			REG_RESET_PAT:   prdata = APB_DW'(cfg_q.reset_pattern);
			REG_ALT_RESET:   prdata = APB_DW'(cfg_q.alt_reset_pattern);
			default:         prdata = '0;
		endcase
	end

endmodule

/* hdl/icp_seq.sv */
// ----------------------------------------------------------------------------
// icp_seq
// Pin sequencer: applies one tick or request per step and forms the result.
// ----------------------------------------------------------------------------
module icp_seq #(
	parameter int FRAME_BITS = icp_pkg::FRAME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  icp_pkg::req_t item,
	input  icp_pkg::cfg_t cfg,
	output icp_pkg::rsp_t result
);
	import icp_pkg::*;

	localparam int BCW = $clog2(FRAME_BITS + 1);
	localparam int SW  = 2 ** BCW;
	localparam logic [63:0] FRAME_MASK = (64'd1 << FRAME_BITS) - 64'd1;

	phase_t          phase_q, phase_n;
	logic [BCW-1:0]  bit_cnt_q, bit_cnt_n;
	logic [15:0]     wait_q, wait_n;
	logic [15:0]     hold_q, hold_n;
	logic [SW-1:0]   shift_q, shift_n;
	logic [7:0]      accum_q, accum_n;
	logic [7:0]      read_hold_q, read_hold_n;
	logic            end_q, end_n;
	logic            pin_clk_q, pin_clk_n;
	logic            pin_dat_q, pin_dat_n;
	logic            pin_dir_q, pin_dir_n;
	logic            pin_rst_q, pin_rst_n;
	logic            done_read;
	logic [63:0]     tx_word;
	logic [15:0]     tx_delay;
	logic [63:0]     rs_word;

	// Word and hold length for the frame-style requests, and the reset pattern word.
	always_comb begin
		case (item.kind)
			KIND_ENTRY: begin
				tx_word  = 64'(item.alternate ? cfg.alt_entry_pattern : cfg.entry_pattern);
				tx_delay = 16'(cfg.pattern_bit_delay);
			end
			KIND_EXIT: begin
				tx_word  = 64'(cfg.exit_pattern);
				tx_delay = 16'(cfg.pattern_bit_delay);
			end
			default: begin
				tx_word  = {40'd0, item.operand, item.command_code};
				tx_delay = 16'(cfg.short_bit_delay);
			end
		endcase
		tx_word = tx_word & FRAME_MASK;
		rs_word = 64'(item.alternate ? cfg.alt_reset_pattern : cfg.reset_pattern);
	end

	always_comb begin
		phase_n     = phase_q;
		bit_cnt_n   = bit_cnt_q;
		wait_n      = wait_q;
		hold_n      = hold_q;
		shift_n     = shift_q;
		accum_n     = accum_q;
		read_hold_n = read_hold_q;
		end_n       = end_q;
		pin_clk_n   = pin_clk_q;
		pin_dat_n   = pin_dat_q;
		pin_dir_n   = pin_dir_q;
		pin_rst_n   = pin_rst_q;
		done_read   = 1'b0;

		if (item.kind == KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				if (wait_q > 16'd1) begin
					wait_n = wait_q - 16'd1;
				end else begin
					case (phase_q)
						PH_TX_LOW: begin
							pin_clk_n = 1'b1;
							phase_n   = PH_TX_HIGH;
							wait_n    = hold_q;
						end
						PH_TX_HIGH: begin
							pin_clk_n = 1'b0;
							if (bit_cnt_q == '0) begin
								phase_n = PH_IDLE;
							end else begin
								bit_cnt_n = bit_cnt_q - BCW'(1);
								pin_dat_n = shift_q[bit_cnt_n];
								phase_n   = PH_TX_LOW;
								wait_n    = hold_q;
							end
						end
						PH_RS_HOLD: begin
							if (bit_cnt_q == '0) begin
								phase_n = PH_IDLE;
							end else begin
								bit_cnt_n = bit_cnt_q - BCW'(1);
								pin_rst_n = shift_q[bit_cnt_n];
								wait_n    = hold_q;
							end
						end
						PH_RD_SETTLE: begin
							phase_n = PH_RD_PRE;
							wait_n  = hold_q;
						end
						PH_RD_PRE: begin
							accum_n   = {accum_q[6:0], item.dat_in};
							pin_clk_n = 1'b1;
							phase_n   = PH_RD_HIGH;
							wait_n    = hold_q;
						end
						PH_RD_HIGH: begin
							pin_clk_n = 1'b0;
							if (bit_cnt_q != '0) begin
								bit_cnt_n = bit_cnt_q - BCW'(1);
							end
							wait_n = hold_q;
							if (bit_cnt_n != '0) begin
								phase_n = PH_RD_PRE;
							end else begin
								pin_dir_n = 1'b1;
								phase_n   = PH_RD_END_DIR;
							end
						end
						PH_RD_END_DIR: begin
							pin_dat_n = end_q;
							phase_n   = PH_RD_END_SET;
							wait_n    = hold_q;
						end
						PH_RD_END_SET: begin
							pin_clk_n = 1'b1;
							phase_n   = PH_RD_END_HIGH;
							wait_n    = hold_q;
						end
						PH_RD_END_HIGH: begin
							pin_clk_n = 1'b0;
							phase_n   = PH_RD_END_LOW;
							wait_n    = hold_q;
						end
						PH_RD_END_LOW: begin
							pin_dat_n   = 1'b0;
							read_hold_n = accum_q;
							phase_n     = PH_IDLE;
							done_read   = 1'b1;
						end
						default: begin
							phase_n = PH_IDLE;
						end
					endcase
				end
			end
		end else if (phase_q == PH_IDLE) begin
			case (item.kind)
				KIND_COMMAND, KIND_ENTRY, KIND_EXIT: begin
					shift_n   = tx_word[SW-1:0];
					bit_cnt_n = BCW'(FRAME_BITS - 1);
					hold_n    = hold_of(tx_delay);
					pin_dir_n = 1'b1;
					pin_dat_n = shift_n[bit_cnt_n];
					wait_n    = hold_n;
					phase_n   = PH_TX_LOW;
				end
				KIND_READ: begin
					hold_n    = hold_of(16'(cfg.short_bit_delay));
					pin_dir_n = 1'b0;
					accum_n   = '0;
					bit_cnt_n = BCW'(8);
					end_n     = item.end_flag;
					wait_n    = hold_n;
					phase_n   = PH_RD_SETTLE;
				end
				KIND_RESET_PAT: begin
					shift_n   = rs_word[SW-1:0];
					bit_cnt_n = BCW'(FRAME_BITS);
					hold_n    = hold_of(cfg.reset_bit_delay);
					pin_rst_n = shift_n[bit_cnt_n];
					wait_n    = hold_n;
					phase_n   = PH_RS_HOLD;
				end
				KIND_SET_RESET: begin
					pin_rst_n = item.reset_level;
				end
				default: ;
			endcase
		end

		result.clk_level  = pin_clk_n;
		result.dat_level  = pin_dir_n & pin_dat_n;
		result.dat_drive  = pin_dir_n;
		result.rst_level  = pin_rst_n;
		result.busy_res   = (phase_n != PH_IDLE);
		result.read_value = read_hold_n;
		result.read_valid = done_read;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= '0;
			wait_q      <= '0;
			hold_q      <= 16'd1;
			shift_q     <= '0;
			accum_q     <= '0;
			read_hold_q <= '0;
			end_q       <= 1'b0;
			pin_clk_q   <= 1'b0;
			pin_dat_q   <= 1'b0;
			pin_dir_q   <= 1'b1;
			pin_rst_q   <= 1'b1;
		end else if (step) begin
			phase_q     <= phase_n;
			bit_cnt_q   <= bit_cnt_n;
			wait_q      <= wait_n;
			hold_q      <= hold_n;
			shift_q     <= shift_n;
			accum_q     <= accum_n;
			read_hold_q <= read_hold_n;
			end_q       <= end_n;
			pin_clk_q   <= pin_clk_n;
			pin_dat_q   <= pin_dat_n;
			pin_dir_q   <= pin_dir_n;
			pin_rst_q   <= pin_rst_n;
		end
	end

endmodule
